// ===== hw/rtl/ipc_pkg.sv =====
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, register indexes, mode and action codes for the irrigation
// pump controller.
// ----------------------------------------------------------------------------
package ipc_pkg;

    // config port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LEVEL_W     = 7;
    localparam int SECONDS_W   = 16;
    localparam int TIME_W      = 32;
    localparam int MS_PER_SECOND = 1000;
    // 65535 * 1000 fits in 26 bits
    localparam int LIMIT_W     = 26;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WATERING_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_LEVEL_ONE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_LEVEL_TWO   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_LEVEL        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_AUTO_RUN_SECONDS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_SECONDS    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMED_RUN_SECONDS = 3'd6;

    // watering modes
    localparam logic [1:0] MODE_AUTO  = 2'd0;
    localparam logic [1:0] MODE_TIMED = 2'd1;
    localparam logic [1:0] MODE_OFF   = 2'd2;

    // action codes
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_STARTED   = 3'd1;
    localparam logic [2:0] ACT_TANK      = 3'd2;
    localparam logic [2:0] ACT_FLOOD     = 3'd3;
    localparam logic [2:0] ACT_MOISTURE  = 3'd4;
    localparam logic [2:0] ACT_TIME      = 3'd5;
    localparam logic [2:0] ACT_OFFMODE   = 3'd6;
    localparam logic [2:0] ACT_INTERLOCK = 3'd7;

    // reset values of the registers, time limits already in milliseconds
    localparam logic [1:0]         RST_MODE         = MODE_OFF;
    localparam logic [LEVEL_W-1:0] RST_START_LEVEL  = 7'd30;
    localparam logic [LEVEL_W-1:0] RST_STOP_LEVEL   = 7'd70;
    localparam logic [LIMIT_W-1:0] RST_AUTO_RUN_MS  = LIMIT_W'(60 * MS_PER_SECOND);
    localparam logic [LIMIT_W-1:0] RST_PERIOD_MS    = LIMIT_W'(3600 * MS_PER_SECOND);
    localparam logic [LIMIT_W-1:0] RST_TIMED_RUN_MS = LIMIT_W'(60 * MS_PER_SECOND);

    typedef struct packed {
        logic signed [7:0]  moisture_one;
        logic signed [7:0]  moisture_two;
        logic               tank_empty;
        logic               no_flood;
        logic [TIME_W-1:0]  now_ms;
    } step_item_t;

    typedef struct packed {
        logic       pump_on;
        logic [2:0] action;
    } result_item_t;

    // decoded configuration seen by the step logic
    typedef struct packed {
        logic [1:0]         mode;
        logic [LEVEL_W-1:0] start_level_one;
        logic [LEVEL_W-1:0] start_level_two;
        logic [LEVEL_W-1:0] stop_level;
        logic [LIMIT_W-1:0] auto_run_ms;
        logic [LIMIT_W-1:0] period_ms;
        logic [LIMIT_W-1:0] timed_run_ms;
    } cfg_t;

    // pump state carried from step to step
    typedef struct packed {
        logic              running;
        logic [TIME_W-1:0] last_start_ms;
    } pump_state_t;

endpackage

// ===== hw/rtl/irrigation_pump_controller.sv =====
// ----------------------------------------------------------------------------
// irrigation_pump_controller
// Pump control step engine: input register, one step of decision logic,
// result register.
// ----------------------------------------------------------------------------
// Takes one control step item per clock while not stalled and returns one
// result item per step, through the input register and then the result
// register. The rate is one item per cycle when nothing stalls, with the pump
// state and last start time updated between steps. The step side stalls
// only while both the input and the result registers hold items and the
// result side is stalled. Configuration writes are taken at any time but are
// meant for when the block is idle; second counts are stored as milliseconds.
module irrigation_pump_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ipc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             step_valid,
    output logic                             step_stall,
    input  ipc_pkg::step_item_t              step_item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output ipc_pkg::result_item_t            result_item
);
    import ipc_pkg::*;

    cfg_t         cfg;
    logic         in_valid_reg;
    step_item_t   in_item_reg;
    logic         out_valid_reg;
    result_item_t out_item_reg;
    pump_state_t  state_reg;
    pump_state_t  state_next;
    result_item_t step_result;
    logic         out_free;
    logic         advance;
    logic         load;

    ipc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipc_step_logic u_step_logic (
        .item       (in_item_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .result     (step_result),
        .state_next (state_next)
    );

    // handshake control
    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign step_stall = in_valid_reg && !out_free;
    assign load       = step_valid && !step_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (load || advance)
            in_valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            in_item_reg <= step_item;
    end

    // pump state, updated as each item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    // checks
    a_interlock_stops: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_item_reg.tank_empty || !in_item_reg.no_flood)
        |=> !state_reg.running)
        else $error("pump still running after interlock");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_item_reg.pump_on == state_reg.running))
        else $error("result pump level differs from pump state");

    a_started_means_on: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.action == ACT_STARTED) |-> out_item_reg.pump_on)
        else $error("start reported with pump off");

    a_stop_means_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_item_reg.action == ACT_TANK
            || out_item_reg.action == ACT_FLOOD || out_item_reg.action == ACT_MOISTURE
            || out_item_reg.action == ACT_TIME || out_item_reg.action == ACT_OFFMODE
            || out_item_reg.action == ACT_INTERLOCK)
        |-> !out_item_reg.pump_on)
        else $error("stop reported with pump on");

    a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(state_reg))
        else $error("held item lost or state changed while waiting");

endmodule

// ===== hw/rtl/ipc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ipc_cfg_regs
// Configuration register file; second counts are converted to milliseconds
// when written so the step path only compares.
// ----------------------------------------------------------------------------
module ipc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ipc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ipc_pkg::cfg_t                    cfg
);
    import ipc_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [LIMIT_W-1:0] data_ms;

    // seconds to milliseconds, constant multiply
    assign data_ms = LIMIT_W'(cfg_data[SECONDS_W-1:0]) * LIMIT_W'(MS_PER_SECOND);

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WATERING_MODE:     cfg_next.mode            = cfg_data[1:0];
                REG_START_LEVEL_ONE:   cfg_next.start_level_one = cfg_data[LEVEL_W-1:0];
                REG_START_LEVEL_TWO:   cfg_next.start_level_two = cfg_data[LEVEL_W-1:0];
                REG_STOP_LEVEL:        cfg_next.stop_level      = cfg_data[LEVEL_W-1:0];
                REG_AUTO_RUN_SECONDS:  cfg_next.auto_run_ms     = data_ms;
                REG_PERIOD_SECONDS:    cfg_next.period_ms       = data_ms;
                REG_TIMED_RUN_SECONDS: cfg_next.timed_run_ms    = data_ms;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= RST_MODE;
            cfg_reg.start_level_one <= RST_START_LEVEL;
            cfg_reg.start_level_two <= RST_START_LEVEL;
            cfg_reg.stop_level      <= RST_STOP_LEVEL;
            cfg_reg.auto_run_ms     <= RST_AUTO_RUN_MS;
            cfg_reg.period_ms       <= RST_PERIOD_MS;
            cfg_reg.timed_run_ms    <= RST_TIMED_RUN_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/ipc_step_logic.sv =====
// ----------------------------------------------------------------------------
// ipc_step_logic
// One control step: interlocks, then the watering mode decision. Produces
// the result item and the next pump state.
// ----------------------------------------------------------------------------
module ipc_step_logic (
    input  ipc_pkg::step_item_t   item,
    input  ipc_pkg::cfg_t         cfg,
    input  ipc_pkg::pump_state_t  state,
    output ipc_pkg::result_item_t result,
    output ipc_pkg::pump_state_t  state_next
);
    import ipc_pkg::*;

    logic              interlock;
    logic [TIME_W-1:0] elapsed;
    logic              below_start;
    logic              at_stop;
    logic              start;
    logic              run_after_start;
    logic [TIME_W-1:0] run_elapsed;
    logic              auto_timeout;
    logic              timed_due;
    logic              timed_done;

    // wrapping time since last start
    assign elapsed = item.now_ms - state.last_start_ms;

    assign interlock = item.tank_empty || !item.no_flood;

    // signed moisture compares, sensor error counts as very dry
    assign below_start = (item.moisture_one < $signed({1'b0, cfg.start_level_one}))
                      || (item.moisture_two < $signed({1'b0, cfg.start_level_two}));
    assign at_stop     = (item.moisture_one >= $signed({1'b0, cfg.stop_level}))
                      || (item.moisture_two >= $signed({1'b0, cfg.stop_level}));

    // start decision per mode
    assign timed_due = elapsed >= TIME_W'(cfg.period_ms);
    assign start = !state.running
                && ((cfg.mode == MODE_AUTO) ? below_start : timed_due);
    assign run_after_start = state.running || start;

    // a pump started in this step has run for zero time
    assign run_elapsed  = start ? '0 : elapsed;
    assign auto_timeout = run_elapsed >= TIME_W'(cfg.auto_run_ms);
    assign timed_done   = run_elapsed >= TIME_W'(cfg.timed_run_ms);

    always_comb
    begin
        state_next     = state;
        result.action  = ACT_NONE;
        if (interlock)
        begin
            state_next.running = 1'b0;
            if (state.running)
                result.action = item.tank_empty ? ACT_TANK : ACT_FLOOD;
            else
                result.action = ACT_INTERLOCK;
        end
        else
        begin
            unique case (cfg.mode)
                MODE_AUTO:
                begin
                    if (start)
                    begin
                        state_next.last_start_ms = item.now_ms;
                        result.action            = ACT_STARTED;
                    end
                    state_next.running = run_after_start;
                    if (run_after_start && at_stop)
                    begin
                        state_next.running = 1'b0;
                        result.action      = ACT_MOISTURE;
                    end
                    else if (run_after_start && auto_timeout)
                    begin
                        state_next.running = 1'b0;
                        result.action      = ACT_TIME;
                    end
                end
                MODE_TIMED:
                begin
                    if (start)
                    begin
                        state_next.last_start_ms = item.now_ms;
                        result.action            = ACT_STARTED;
                    end
                    state_next.running = run_after_start;
                    if (run_after_start && timed_done)
                    begin
                        state_next.running = 1'b0;
                        result.action      = ACT_TIME;
                    end
                end
                MODE_OFF:
                begin
                    state_next.running = 1'b0;
                    result.action      = ACT_OFFMODE;
                end
                // unused mode code keeps the state
                default:
                begin
                    state_next    = state;
                    result.action = ACT_NONE;
                end
            endcase
        end
        result.pump_on = state_next.running;
    end

endmodule

// ===== dv/pump_step_checker.sv =====
// ----------------------------------------------------------------------------
// pump_step_checker
// Watches the config port and both item channels of the irrigation pump
// controller, keeps its own copy of the settings and pump state, predicts
// the result of every accepted control step and compares it in order with
// the results the block hands out.
// ----------------------------------------------------------------------------
module pump_step_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ipc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             step_valid,
    input  logic                             step_stall,
    input  ipc_pkg::step_item_t              step_item,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  ipc_pkg::result_item_t            result_item,
    output int                               mismatches,
    output int                               outstanding,
    output int                               results_checked
);

    import ipc_pkg::*;

    // shadow copy of the settings
    logic [1:0]         mode;
    logic [LEVEL_W-1:0] lvl_one;
    logic [LEVEL_W-1:0] lvl_two;
    logic [LEVEL_W-1:0] lvl_stop;
    logic [15:0]        auto_run_s;
    logic [15:0]        period_s;
    logic [15:0]        timed_run_s;

    // shadow pump state
    logic               running;
    logic [TIME_W-1:0]  last_start;

    result_item_t       predicted_results[$];
    result_item_t       want;
    int                 fail_total;
    int                 seen_total;

    // one control step: updates the shadow state, returns the expected item
    function automatic result_item_t pump_step(input step_item_t it);
        int                m1;
        int                m2;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] auto_ms;
        logic [TIME_W-1:0] period_ms;
        logic [TIME_W-1:0] timed_ms;
        logic [2:0]        act;
        result_item_t      r;
        m1        = int'($signed(it.moisture_one));
        m2        = int'($signed(it.moisture_two));
        auto_ms   = {16'd0, auto_run_s} * TIME_W'(MS_PER_SECOND);
        period_ms = {16'd0, period_s} * TIME_W'(MS_PER_SECOND);
        timed_ms  = {16'd0, timed_run_s} * TIME_W'(MS_PER_SECOND);
        act       = ACT_NONE;
        // interlocks come first, tank before flood
        if (it.tank_empty || !it.no_flood)
        begin
            if (running)
            begin
                running = 1'b0;
                act     = it.tank_empty ? ACT_TANK : ACT_FLOOD;
            end
            else
            begin
                act = ACT_INTERLOCK;
            end
        end
        else
        begin
            case (mode)
                MODE_AUTO:
                begin
                    if ((m1 < int'(lvl_one) || m2 < int'(lvl_two)) && !running)
                    begin
                        running    = 1'b1;
                        last_start = it.now_ms;
                        act        = ACT_STARTED;
                    end
                    if (running)
                    begin
                        elapsed = it.now_ms - last_start;
                        if (m1 >= int'(lvl_stop) || m2 >= int'(lvl_stop))
                        begin
                            running = 1'b0;
                            act     = ACT_MOISTURE;
                        end
                        else if (elapsed >= auto_ms)
                        begin
                            running = 1'b0;
                            act     = ACT_TIME;
                        end
                    end
                end
                MODE_TIMED:
                begin
                    elapsed = it.now_ms - last_start;
                    if (!running && elapsed >= period_ms)
                    begin
                        running    = 1'b1;
                        last_start = it.now_ms;
                        act        = ACT_STARTED;
                    end
                    elapsed = it.now_ms - last_start;
                    if (running && elapsed >= timed_ms)
                    begin
                        running = 1'b0;
                        act     = ACT_TIME;
                    end
                end
                MODE_OFF:
                begin
                    running = 1'b0;
                    act     = ACT_OFFMODE;
                end
                // the unused mode code leaves everything as it is
                default:
                begin
                end
            endcase
        end
        r.pump_on = running;
        r.action  = act;
        return r;
    endfunction

    // track config writes, predict on step items, compare on result items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode        = RST_MODE;
            lvl_one     = RST_START_LEVEL;
            lvl_two     = RST_START_LEVEL;
            lvl_stop    = RST_STOP_LEVEL;
            auto_run_s  = 16'd60;
            period_s    = 16'd3600;
            timed_run_s = 16'd60;
            running     = 1'b0;
            last_start  = '0;
            fail_total  = 0;
            seen_total  = 0;
            predicted_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WATERING_MODE:     mode        = cfg_data[1:0];
                    REG_START_LEVEL_ONE:   lvl_one     = cfg_data[LEVEL_W-1:0];
                    REG_START_LEVEL_TWO:   lvl_two     = cfg_data[LEVEL_W-1:0];
                    REG_STOP_LEVEL:        lvl_stop    = cfg_data[LEVEL_W-1:0];
                    REG_AUTO_RUN_SECONDS:  auto_run_s  = cfg_data[15:0];
                    REG_PERIOD_SECONDS:    period_s    = cfg_data[15:0];
                    REG_TIMED_RUN_SECONDS: timed_run_s = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (step_valid && !step_stall)
                predicted_results.push_back(pump_step(step_item));
            if (result_valid && !result_stall)
            begin
                seen_total++;
                if (predicted_results.size() == 0)
                begin
                    $error("unexpected result item: pump_on %0b action %0d",
                           result_item.pump_on, result_item.action);
                    fail_total++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result_item.pump_on !== want.pump_on)
                    begin
                        $error("pump_on: expected %0b, got %0b",
                               want.pump_on, result_item.pump_on);
                        fail_total++;
                    end
                    if (result_item.action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d",
                               want.action, result_item.action);
                        fail_total++;
                    end
                end
            end
        end
        mismatches      <= fail_total;
        outstanding     <= predicted_results.size();
        results_checked <= seen_total;
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the irrigation pump controller. A directed part
// walks through interlocks, sensor errors, start and stop in one step, time
// wrap, every mode and the setting extremes; then random settings phases run
// with varied sender idling and receiver stalls, including a long output
// hold-off. Checking is done by pump_step_checker.
// ----------------------------------------------------------------------------
module tb;

    import ipc_pkg::*;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         HOLD_OFF_CYCLES = 40;
    localparam int         LATENCY_CYCLES  = 4;
    localparam int         RANDOM_PHASES   = 24;

    typedef struct packed {
        logic [1:0]         mode;
        logic [LEVEL_W-1:0] lvl_one;
        logic [LEVEL_W-1:0] lvl_two;
        logic [LEVEL_W-1:0] lvl_stop;
        logic [15:0]        auto_s;
        logic [15:0]        period_s;
        logic [15:0]        timed_s;
    } pump_settings_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   step_valid = 1'b0;
    logic                   step_stall;
    step_item_t             step_item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_item_t           result_item;

    int                     mismatches;
    int                     outstanding;
    int                     results_checked;

    int                     idle_pct = 0;
    int                     stall_pct = 0;
    int                     hold_requests = 0;
    int                     holds_done = 0;
    int                     hold_left = 0;
    int                     steps_sent = 0;
    int                     phases_run = 0;
    logic [TIME_W-1:0]      clock_ms = '0;
    pump_settings_t         cur;

    irrigation_pump_controller i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .step_valid   (step_valid),
        .step_stall   (step_stall),
        .step_item    (step_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    pump_step_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .step_valid      (step_valid),
        .step_stall      (step_stall),
        .step_item       (step_item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result_item     (result_item),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_left == 0 && holds_done != hold_requests)
        begin
            hold_left  = HOLD_OFF_CYCLES;
            holds_done = holds_done + 1;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic step_item_t control_step(input int m1, input int m2,
                                                input bit tank, input bit dry,
                                                input logic [TIME_W-1:0] now);
        step_item_t it;
        it.moisture_one = 8'(m1);
        it.moisture_two = 8'(m2);
        it.tank_empty   = tank;
        it.no_flood     = dry;
        it.now_ms       = now;
        return it;
    endfunction

    function automatic pump_settings_t make_settings(
        input logic [1:0] mode, input int l1, input int l2, input int stop,
        input int auto_s, input int period_s, input int timed_s);
        pump_settings_t s;
        s.mode     = mode;
        s.lvl_one  = LEVEL_W'(l1);
        s.lvl_two  = LEVEL_W'(l2);
        s.lvl_stop = LEVEL_W'(stop);
        s.auto_s   = 16'(auto_s);
        s.period_s = 16'(period_s);
        s.timed_s  = 16'(timed_s);
        return s;
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 10)
            return 7'd0;
        else if (p < 20)
            return 7'd100;
        else if (p < 25)
            return 7'd127;
        return LEVEL_W'($urandom_range(10, 90));
    endfunction

    function automatic logic [15:0] pick_seconds();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 8)
            return 16'd0;
        else if (p < 13)
            return 16'hFFFF;
        else if (p < 33)
            return 16'($urandom_range(65535));
        return 16'($urandom_range(1, 30));
    endfunction

    function automatic pump_settings_t random_settings();
        pump_settings_t s;
        int unsigned    p;
        p = $urandom_range(99);
        if (p < 40)
            s.mode = MODE_AUTO;
        else if (p < 80)
            s.mode = MODE_TIMED;
        else if (p < 92)
            s.mode = MODE_OFF;
        else
            s.mode = MODE_UNUSED;
        s.lvl_one  = pick_level();
        s.lvl_two  = pick_level();
        s.lvl_stop = pick_level();
        s.auto_s   = pick_seconds();
        s.period_s = pick_seconds();
        s.timed_s  = pick_seconds();
        return s;
    endfunction

    function automatic logic [7:0] pick_moisture();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 8)
            return 8'($urandom_range(255));
        else if (p < 16)
            return 8'hFF;
        return 8'($urandom_range(100));
    endfunction

    // random step: time mostly moves forward on the scale of the limits
    function automatic step_item_t random_step();
        step_item_t  it;
        int unsigned longest;
        int unsigned span;
        int unsigned p;
        longest = cur.auto_s;
        if (cur.period_s > longest)
            longest = cur.period_s;
        if (cur.timed_s > longest)
            longest = cur.timed_s;
        span = longest * MS_PER_SECOND / 3 + 10;
        p = $urandom_range(99);
        if (p < 70)
            clock_ms = clock_ms + $urandom_range(span);
        else if (p < 92)
            clock_ms = clock_ms + $urandom_range(span * 4);
        else
            clock_ms = $urandom();
        it.moisture_one = pick_moisture();
        it.moisture_two = pick_moisture();
        it.tank_empty   = ($urandom_range(99) < 7);
        it.no_flood     = !($urandom_range(99) < 7);
        it.now_ms       = clock_ms;
        return it;
    endfunction

    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_settings(input pump_settings_t s);
        reg_write(REG_WATERING_MODE, CFG_DATA_W'(s.mode));
        reg_write(REG_START_LEVEL_ONE, CFG_DATA_W'(s.lvl_one));
        reg_write(REG_START_LEVEL_TWO, CFG_DATA_W'(s.lvl_two));
        reg_write(REG_STOP_LEVEL, CFG_DATA_W'(s.lvl_stop));
        reg_write(REG_AUTO_RUN_SECONDS, s.auto_s);
        reg_write(REG_PERIOD_SECONDS, s.period_s);
        reg_write(REG_TIMED_RUN_SECONDS, s.timed_s);
        cfg_we <= 1'b0;
        cur = s;
        phases_run++;
    endtask

    task automatic send_step(input step_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            step_valid <= 1'b0;
            @(posedge clk);
        end
        step_valid <= 1'b1;
        step_item  <= it;
        @(posedge clk);
        while (step_stall)
            @(posedge clk);
        steps_sent++;
    endtask

    // stop offering items and wait for every expected result
    task automatic drain();
        step_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // auto mode: interlocks, sensor errors, start and stop together, time wrap
        write_settings(make_settings(MODE_AUTO, 30, 30, 70, 60, 3600, 60));
        send_step(control_step(20, 50, 0, 1, 32'd1000));
        send_step(control_step(40, 40, 0, 1, 32'd2000));
        send_step(control_step(40, 40, 1, 1, 32'd3000));
        send_step(control_step(40, 40, 1, 1, 32'd4000));
        send_step(control_step(-1, 40, 0, 1, 32'd5000));
        send_step(control_step(40, 40, 0, 0, 32'd6000));
        send_step(control_step(-128, 40, 0, 1, 32'd7000));
        send_step(control_step(40, 40, 1, 0, 32'd8000));
        send_step(control_step(40, 40, 1, 0, 32'd9000));
        send_step(control_step(10, 80, 0, 1, 32'd10000));
        send_step(control_step(127, 127, 0, 1, 32'd11000));
        send_step(control_step(0, 50, 0, 1, 32'hFFFF_FF00));
        send_step(control_step(50, 50, 0, 1, 32'h0000_EA00));
        drain();

        // zero limits: timed start and stop in one step
        write_settings(make_settings(MODE_TIMED, 0, 0, 0, 0, 0, 0));
        send_step(control_step(50, 50, 0, 1, 32'd20000));
        drain();

        // out of range levels and the longest auto run
        write_settings(make_settings(MODE_AUTO, 127, 127, 127, 65535, 65535, 65535));
        send_step(control_step(100, 100, 0, 1, 32'd0));
        send_step(control_step(126, 126, 0, 1, 32'd65534999));
        send_step(control_step(126, 126, 0, 1, 32'd65535000));
        drain();

        // longest period, pump left running
        write_settings(make_settings(MODE_TIMED, 100, 100, 100, 65535, 65535, 65535));
        send_step(control_step(50, 50, 0, 1, 32'd65534999));
        send_step(control_step(50, 50, 0, 1, 32'd65535000));
        drain();

        // unused mode code keeps the running pump
        write_settings(make_settings(MODE_UNUSED, 30, 30, 70, 60, 3600, 60));
        send_step(control_step(0, 0, 0, 1, 32'd65536000));
        drain();

        // off mode from running, again while off, interlock while off
        write_settings(make_settings(MODE_OFF, 30, 30, 70, 60, 3600, 60));
        send_step(control_step(50, 50, 0, 1, 32'd65537000));
        send_step(control_step(50, 50, 0, 1, 32'd65538000));
        send_step(control_step(50, 50, 1, 1, 32'd65539000));
        drain();

        // long result hold-off with the sender never idle
        write_settings(make_settings(MODE_AUTO, 40, 40, 60, 5, 10, 5));
        cur = make_settings(MODE_AUTO, 40, 40, 60, 5, 10, 5);
        idle_pct = 0;
        stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        repeat (60) send_step(random_step());
        drain();

        // random phases, cycling through the idling patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_settings(random_settings());
            case (ph % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 58;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 58;
                end
                default:
                begin
                    idle_pct = 18;
                    stall_pct <= 18;
                end
            endcase
            if (ph == RANDOM_PHASES / 2)
                hold_requests <= hold_requests + 1;
            n = $urandom_range(50, 100);
            repeat (n) send_step(random_step());
            drain();
        end

        $display("run covered %0d control steps over %0d settings phases", steps_sent,
                 phases_run);
        $display("all modes, interlocks, sensor errors and time wrap; %0d results checked",
                 results_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ipc_pkg.sv
hw/rtl/ipc_cfg_regs.sv
hw/rtl/ipc_step_logic.sv
hw/rtl/irrigation_pump_controller.sv
dv/pump_step_checker.sv
dv/tb.sv
